// ----- src/tt_pkg.sv -----
// Shared types, constants and table functions for the thermistor converter.
package tt_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CODE_W  = 12;   // adc_code width
  localparam int COEF_W  = 32;   // coefficient register width
  localparam int CFG_IDX_W = 2;
  localparam int LW      = 24;   // log-ratio width, Q16 signed
  localparam int ACC_W   = 64;   // Horner accumulator, Q36
  localparam int QW      = 53;   // reciprocal quotient bits, Q16 kelvin
  localparam int TW      = QW + 2;
  localparam int TEMP_W  = 24;
  localparam int STAT_W  = 2;

  localparam longint LN2_Q30    = 64'sd744261118;
  localparam longint KELVIN_Q16 = 64'sd17901814;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7FFFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONST  = 2'd0,
    CFG_LINEAR = 2'd1,
    CFG_SQUARE = 2'd2,
    CFG_CUBE   = 2'd3
  } tt_cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_RAIL = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } tt_status_t;

  // Per-stage sideband that rides with the data.
  typedef struct packed {
    logic vld;
    logic rail;
    logic zero;
  } tt_tag_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
  } tt_coef_t;

  // log2 of n in Q16, fraction by repeated squaring of a Q30 mantissa.
  function automatic longint log2_q16(input int unsigned n);
    int unsigned     k;
    longint unsigned m;
    int unsigned     frac;
    k    = 0;
    frac = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = 64'(n) << (30 - k);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        frac = frac | (32'd1 << b);
      end
    end
    return (longint'(k) << 16) | longint'(frac);
  endfunction

  // ln(i / (ts - i)) in Q16; entry zero is never used.
  function automatic logic signed [LW-1:0] rom_entry(input int unsigned i,
                                                      input int unsigned ts);
    longint d;
    longint r;
    if (i == 0) return '0;
    d = log2_q16(i) - log2_q16(ts - i);
    r = (d * LN2_Q30 + (64'sd1 <<< 29)) >>> 30;
    return r[LW-1:0];
  endfunction

endpackage

// ----- src/tt_stream_if.sv -----
// Request channels of the converter: sample in, temperature out.
interface tt_in_if import tt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;
  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface tt_out_if import tt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_c;
  logic [STAT_W-1:0]        status;
  modport source (output valid, output temperature_c, output status, input ready);
  modport sink   (input valid, input temperature_c, input status, output ready);
endinterface

// ----- src/tt_log_interp.sv -----
// Segment split, log-ratio table lookup and linear interpolation (4 stages).
module tt_log_interp import tt_pkg::*; #(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [CODE_W-1:0]    code,
  output tt_tag_t              tag_o,
  output logic signed [LW-1:0] l_o
);
  localparam int SB   = SAMPLE_BITS;
  localparam int IW   = $clog2(TABLE_SIZE);
  localparam int PW   = CODE_W + $clog2(TABLE_SIZE + 1);
  localparam int SEGW = PW - SB;
  localparam int PRW  = LW + SB + 2;

  logic signed [LW-1:0] rom [TABLE_SIZE];
  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    assign rom[gi] = rom_entry(gi, TABLE_SIZE);
  end

  // stage 1: segment index and remainder
  logic [PW-1:0]   p;
  logic [SEGW-1:0] seg_full;
  logic [31:0]     seg_wide;
  logic            last;
  logic [IW-1:0]   seg_nxt, seg1_nxt;
  logic [SB-1:0]   rem_nxt;
  tt_tag_t         tag1_r;
  logic [IW-1:0]   seg_r, seg1_r;
  logic [SB-1:0]   rem1_r;

  always_comb begin
    p        = PW'(code) * PW'(TABLE_SIZE);
    seg_full = p[PW-1:SB];
    seg_wide = 32'(seg_full);
    last     = seg_wide >= 32'(TABLE_SIZE - 1);
    seg_nxt  = last ? IW'(TABLE_SIZE - 1) : seg_wide[IW-1:0];
    seg1_nxt = last ? IW'(TABLE_SIZE - 1) : seg_wide[IW-1:0] + IW'(1);
    rem_nxt  = last ? '0 : p[SB-1:0];
  end

  // stage 2: table reads
  tt_tag_t              tag2_r;
  logic signed [LW-1:0] t0_r, t1_r;
  logic [SB-1:0]        rem2_r;

  // stage 3: weighted products
  logic [SB:0]           w0;
  logic signed [PRW-1:0] pa_nxt, pb_nxt;
  tt_tag_t               tag3_r;
  logic signed [PRW-1:0] pa_r, pb_r;

  assign w0     = {1'b1, SB'(0)} - {1'b0, rem2_r};
  assign pa_nxt = t0_r * $signed({1'b0, w0});
  assign pb_nxt = t1_r * $signed({2'b0, rem2_r});

  // stage 4: rounded sum
  logic signed [PRW-1:0] sum;
  logic signed [PRW-1:0] sum_sh;
  tt_tag_t               tag4_r;
  logic signed [LW-1:0]  l_r;

  assign sum    = pa_r + pb_r + (PRW'(1) <<< (SB - 1));
  assign sum_sh = sum >>> SB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag1_r <= '{vld: in_vld, rail: (seg_full == '0), zero: 1'b0};
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r  <= seg_nxt;
      seg1_r <= seg1_nxt;
      rem1_r <= rem_nxt;
      t0_r   <= rom[seg_r];
      t1_r   <= rom[seg1_r];
      rem2_r <= rem1_r;
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      l_r    <= sum_sh[LW-1:0];
    end
  end

  assign tag_o = tag4_r;
  assign l_o   = l_r;
endmodule

// ----- src/tt_horner.sv -----
// Cubic in the log ratio, Horner form, two stages per step.
module tt_horner import tt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tt_coef_t                coef,
  input  tt_tag_t                 tag_i,
  input  logic signed [LW-1:0]    l_i,
  output tt_tag_t                 tag_o,
  output logic signed [ACC_W-1:0] acc_o
);
  localparam int NSTEP = 3;
  localparam int PLW   = 33 + LW;
  localparam int PHW   = 32 + LW;
  localparam int PFW   = ACC_W + LW;

  tt_tag_t                 tag_c [NSTEP+1];
  logic signed [LW-1:0]    l_c   [NSTEP+1];
  logic signed [ACC_W-1:0] acc_c [NSTEP+1];
  logic signed [COEF_W-1:0] add_c [NSTEP];

  assign tag_c[0] = tag_i;
  assign l_c[0]   = l_i;
  assign acc_c[0] = ACC_W'(coef.c3);
  assign add_c[0] = coef.c2;
  assign add_c[1] = coef.c1;
  assign add_c[2] = coef.c0;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    logic signed [PLW-1:0]   plo_nxt, plo_r;
    logic signed [PHW-1:0]   phi_nxt, phi_r;
    tt_tag_t                 taga_r, tagb_r;
    logic signed [LW-1:0]    la_r, lb_r;
    logic signed [PFW-1:0]   prod;
    logic signed [PFW-1:0]   prod_sh;
    logic signed [ACC_W-1:0] acc_nxt, acc_r;

    // split the accumulator so that each partial product stays narrow
    assign plo_nxt = $signed({1'b0, acc_c[g][31:0]}) * l_c[g];
    assign phi_nxt = $signed(acc_c[g][63:32]) * l_c[g];
    assign prod    = (PFW'(phi_r) <<< 32) + PFW'(plo_r);
    assign prod_sh = prod >>> 16;
    assign acc_nxt = prod_sh[ACC_W-1:0] + ACC_W'(add_c[g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        taga_r <= '0;
        tagb_r <= '0;
      end else if (en) begin
        taga_r <= tag_c[g];
        tagb_r <= taga_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        plo_r <= plo_nxt;
        phi_r <= phi_nxt;
        la_r  <= l_c[g];
        lb_r  <= la_r;
        acc_r <= acc_nxt;
      end
    end

    assign tag_c[g+1] = tagb_r;
    assign l_c[g+1]   = lb_r;
    assign acc_c[g+1] = acc_r;
  end

  assign tag_o = tag_c[NSTEP];
  assign acc_o = acc_c[NSTEP];
endmodule

// ----- src/tt_recip.sv -----
// Rounded reciprocal 2^52 / |acc|, restoring division one quotient bit per stage.
module tt_recip import tt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tt_tag_t                 tag_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output tt_tag_t                 tag_o,
  output logic                    neg_o,
  output logic [QW-1:0]           q_o
);
  // init stage: magnitude, rounded numerator, zero flag
  logic [ACC_W-1:0] mag_nxt, num_nxt;
  tt_tag_t          tag0_nxt;

  always_comb begin
    mag_nxt       = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    num_nxt       = (ACC_W'(1) << 52) + (mag_nxt >> 1);
    tag0_nxt      = tag_i;
    tag0_nxt.zero = (acc_i == '0);
  end

  tt_tag_t          tag_c [QW+1];
  logic             neg_c [QW+1];
  logic [ACC_W-1:0] mag_c [QW+1];
  logic [ACC_W-1:0] num_c [QW+1];
  logic [ACC_W-1:0] rem_c [QW+1];
  logic [QW-1:0]    q_c   [QW+1];

  tt_tag_t          tag0_r;
  logic             neg0_r;
  logic [ACC_W-1:0] mag0_r, num0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tag0_r <= '0;
    else if (en) tag0_r <= tag0_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= acc_i[ACC_W-1];
      mag0_r <= mag_nxt;
      num0_r <= num_nxt;
    end
  end

  assign tag_c[0] = tag0_r;
  assign neg_c[0] = neg0_r;
  assign mag_c[0] = mag0_r;
  assign num_c[0] = num0_r;
  // quotient fits in QW bits, so the bits above it seed the remainder
  assign rem_c[0] = ACC_W'(num0_r[ACC_W-1:QW]);
  assign q_c[0]   = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int BIT = QW - 1 - g;
    logic [ACC_W:0]   cand;
    logic             ge;
    logic [ACC_W:0]   diff;
    logic [ACC_W-1:0] rem_nxt, rem_r;
    tt_tag_t          tag_r;
    logic             neg_r;
    logic [ACC_W-1:0] mag_r, num_r;
    logic [QW-1:0]    q_r;

    assign cand    = {rem_c[g], num_c[g][BIT]};
    assign ge      = cand >= {1'b0, mag_c[g]};
    assign diff    = cand - {1'b0, mag_c[g]};
    assign rem_nxt = ge ? diff[ACC_W-1:0] : cand[ACC_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) tag_r <= '0;
      else if (en) tag_r <= tag_c[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        q_r   <= {q_c[g][QW-2:0], ge};
        neg_r <= neg_c[g];
        mag_r <= mag_c[g];
        num_r <= num_c[g];
      end
    end

    assign tag_c[g+1] = tag_r;
    assign neg_c[g+1] = neg_r;
    assign mag_c[g+1] = mag_r;
    assign num_c[g+1] = num_r;
    assign rem_c[g+1] = rem_r;
    assign q_c[g+1]   = q_r;
  end

  assign tag_o = tag_c[QW];
  assign neg_o = neg_c[QW];
  assign q_o   = q_c[QW];
endmodule

// ----- src/thermistor_temperature_convert.sv -----
// Top level: thermistor ADC code to Celsius, fully pipelined.
//
// Usage:
//   in_chan  (sink): one request carries a 12-bit adc_code from a pulled-up
//            thermistor divider. A request is taken when valid and ready are
//            both high.
//   out_chan (source): one request per sample, temperature_c in 1/256 degC
//            (signed 24 bit) and status (ok, sensor at rail, zero divisor,
//            saturated). Results leave in sample order.
//   cfg_*:   write port for the four Q36 coefficients, index 0..3
//            (constant, linear, square, cube). Write only while idle.
// Throughput: one sample per cycle while out_chan is not stalled; every stage advances together.
// Pipeline: 4 table and interpolation stages, 6 Horner stages, 54
//   reciprocal stages (one quotient bit per stage through the restoring
//   divider) and 2 output stages between acceptance and out_chan.valid.
// Reset: clears every valid bit and the coefficient registers; no sweep.
// Stall: when out_chan.ready is low with a result pending, the whole pipe
//   holds and in_chan.ready drops; nothing is dropped or repeated.
module thermistor_temperature_convert import tt_pkg::*; #(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tt_in_if.sink                in_chan,
  tt_out_if.source             out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  // Coefficient registers; a write lands on the addressed one only.
  tt_coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (tt_cfg_idx_t'(cfg_index))
        CFG_CONST:  coef_r.c0 <= cfg_wdata;
        CFG_LINEAR: coef_r.c1 <= cfg_wdata;
        CFG_SQUARE: coef_r.c2 <= cfg_wdata;
        CFG_CUBE:   coef_r.c3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One enable for the whole pipe: advance unless the output is blocked.
  logic en;
  logic out_vld_r;

  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  tt_tag_t              tag_l;
  logic signed [LW-1:0] l_val;

  tt_log_interp #(
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_chan.valid),
    .code   (in_chan.adc_code),
    .tag_o  (tag_l),
    .l_o    (l_val)
  );

  tt_tag_t                 tag_h;
  logic signed [ACC_W-1:0] acc;

  tt_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .coef  (coef_r),
    .tag_i (tag_l),
    .l_i   (l_val),
    .tag_o (tag_h),
    .acc_o (acc)
  );

  tt_tag_t       tag_q;
  logic          neg_q;
  logic [QW-1:0] q_val;

  tt_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_h),
    .acc_i (acc),
    .tag_o (tag_q),
    .neg_o (neg_q),
    .q_o   (q_val)
  );

  // Post stage 1: apply sign, subtract 273.16 K, round to 1/256 degree.
  logic signed [TW-1:0] qs;
  logic signed [TW-1:0] v;
  logic signed [TW-1:0] t_nxt;
  tt_tag_t              tagp_r;
  logic signed [TW-1:0] t_r;

  always_comb begin
    qs    = neg_q ? -$signed({2'b0, q_val}) : $signed({2'b0, q_val});
    v     = qs - TW'(KELVIN_Q16) + TW'(128);
    t_nxt = v >>> 8;
  end

  // Post stage 2: saturate and pick the status; this is the output register.
  logic signed [TEMP_W-1:0] temp_nxt, temp_r;
  tt_status_t               stat_nxt, stat_r;

  always_comb begin
    if (tagp_r.rail) begin
      temp_nxt = TEMP_MAX;
      stat_nxt = ST_RAIL;
    end else if (tagp_r.zero) begin
      temp_nxt = TEMP_MAX;
      stat_nxt = ST_ZERO;
    end else if (t_r > TW'(TEMP_MAX)) begin
      temp_nxt = TEMP_MAX;
      stat_nxt = ST_SAT;
    end else if (t_r < TW'(TEMP_MIN)) begin
      temp_nxt = TEMP_MIN;
      stat_nxt = ST_SAT;
    end else begin
      temp_nxt = t_r[TEMP_W-1:0];
      stat_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tagp_r    <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      tagp_r    <= tag_q;
      out_vld_r <= tagp_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      temp_r <= temp_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.temperature_c = temp_r;
  assign out_chan.status        = stat_r;
endmodule

// ----- src/tt_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module tt_port_checks import tt_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TEMP_W-1:0] temperature_c,
  input logic [STAT_W-1:0]        status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_RAIL || status == ST_ZERO) |-> temperature_c == TEMP_MAX)
    else $error("fault result not at upper bound");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SAT |-> temperature_c == TEMP_MAX || temperature_c == TEMP_MIN)
    else $error("saturated result not at a bound");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind thermistor_temperature_convert tt_port_checks u_tt_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .temperature_c (out_chan.temperature_c),
  .status        (out_chan.status)
);

// ----- test/tt_checker.sv -----
// Scoreboard for the thermistor converter: predicts each temperature and checks results.
`timescale 1ns / 100ps
module tt_checker import tt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tt_in_if                  in_mon,
  tt_out_if                 out_mon,
  input  logic              cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                status_seen [4]
);

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    tt_status_t               status;
  } temp_result_t;

  temp_result_t awaited_temps [$];
  longint       log_ratio [256];
  longint       k_const, k_linear, k_square, k_cube;

  function automatic longint log2_fixed(input int unsigned n);
    int unsigned     ip;
    longint unsigned mant;
    longint          fr;
    ip = 0;
    fr = 0;
    while (ip < 31 && (n >> (ip + 1)) != 0) ip++;
    mant = longint'(n) << (30 - ip);
    for (int b = 15; b >= 0; b--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        fr   = fr | (64'd1 << b);
      end
    end
    return (longint'(ip) << 16) | fr;
  endfunction

  initial begin
    longint d;
    log_ratio[0] = 0;
    for (int i = 1; i < 256; i++) begin
      d = log2_fixed(i) - log2_fixed(256 - i);
      log_ratio[i] = (d * LN2_Q30 + (64'sd1 <<< 29)) >>> 30;
    end
  end

  // Segment lookup, interpolation, Horner, reciprocal and Celsius offset.
  function automatic temp_result_t convert_sample(input logic [CODE_W-1:0] code);
    temp_result_t    r;
    int unsigned     seg, frac;
    longint          lr, acc, mag, q, t;
    longint unsigned num;
    seg  = code >> 4;
    frac = int'(code[3:0]) << 8;
    if (seg == 0) begin
      r.temp   = TEMP_MAX;
      r.status = ST_RAIL;
      return r;
    end
    if (seg >= 255) lr = log_ratio[255];
    else lr = (log_ratio[seg] * longint'(4096 - frac) + log_ratio[seg + 1] * longint'(frac)
               + 2048) >>> 12;
    acc = k_cube;
    acc = ((acc * lr) >>> 16) + k_square;
    acc = ((acc * lr) >>> 16) + k_linear;
    acc = ((acc * lr) >>> 16) + k_const;
    if (acc == 0) begin
      r.temp   = TEMP_MAX;
      r.status = ST_ZERO;
      return r;
    end
    mag = (acc < 0) ? -acc : acc;
    num = (64'd1 << 52) + longint'(mag / 2);
    q   = longint'(num / longint'(mag));
    if (acc < 0) q = -q;
    t = (q - KELVIN_Q16 + 128) >>> 8;
    r.status = ST_OK;
    if (t > longint'(TEMP_MAX)) begin
      t        = TEMP_MAX;
      r.status = ST_SAT;
    end else if (t < longint'(TEMP_MIN)) begin
      t        = TEMP_MIN;
      r.status = ST_SAT;
    end
    r.temp = t[TEMP_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors  = 0;
    checked = 0;
    pending = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end

  always @(posedge clk) begin
    temp_result_t want;
    if (!rst_n) begin
      k_const  = 0;
      k_linear = 0;
      k_square = 0;
      k_cube   = 0;
    end else begin
      if (cfg_we) begin
        case (tt_cfg_idx_t'(cfg_index))
          CFG_CONST:  k_const  = longint'($signed(cfg_wdata));
          CFG_LINEAR: k_linear = longint'($signed(cfg_wdata));
          CFG_SQUARE: k_square = longint'($signed(cfg_wdata));
          CFG_CUBE:   k_cube   = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_temps.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = awaited_temps.pop_front();
          checked++;
          status_seen[want.status]++;
          if (out_mon.temperature_c !== want.temp || out_mon.status !== want.status)
            report_mismatch($sformatf("temperature_c %0d status %0d, predicted %0d status %0d",
                                      out_mon.temperature_c, out_mon.status,
                                      want.temp, want.status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_temps.push_back(convert_sample(in_mon.adc_code));
    end
    pending = awaited_temps.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the converter test: clock, reset, sample stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module testbench import tt_pkg::*; ();

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_wdata;
  logic                 long_hold;
  int                   errors, pending, checked;
  int                   status_seen [4];

  tt_in_if  in_chan ();
  tt_out_if out_chan ();

  thermistor_temperature_convert uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan.sink),
    .out_chan  (out_chan.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tt_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .status_seen (status_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hard stop in case the pipe locks up.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stretches of random stall density; a requested long hold
  // keeps ready low long enough for the whole pipe to fill and back up.
  initial begin
    int len, density;
    out_chan.ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        len     = $urandom_range(1, 80);
        density = $urandom_range(0, 3);
        repeat (len) begin
          out_chan.ready <= (density == 0) ? 1'b1 : ($urandom_range(0, 3) >= density);
          @(posedge clk);
        end
      end
    end
  end

  // Offer one sample and hold it until taken.
  task automatic send_sample(input logic [CODE_W-1:0] code);
    in_chan.valid    <= 1'b1;
    in_chan.adc_code <= code;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drop valid for a random gap at the end of a burst.
  int burst_left;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    if ($urandom_range(0, 2) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drain the pipe, then load all four coefficients back to back.
  task automatic load_coefs(input logic [COEF_W-1:0] c0, c1, c2, c3);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (70) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONST;
    cfg_wdata <= c0;
    @(posedge clk);
    cfg_index <= CFG_LINEAR;
    cfg_wdata <= c1;
    @(posedge clk);
    cfg_index <= CFG_SQUARE;
    cfg_wdata <= c2;
    @(posedge clk);
    cfg_index <= CFG_CUBE;
    cfg_wdata <= c3;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Rail, segment edges, mid scale and the clamped last segment.
  task automatic edge_codes();
    logic [CODE_W-1:0] codes [12] = '{12'd0, 12'd15, 12'd16, 12'd17, 12'd31, 12'd2048,
                                      12'd2730, 12'd4063, 12'd4079, 12'd4080, 12'd4094,
                                      12'd4095};
    foreach (codes[i]) send_sample(codes[i]);
  endtask

  // Random sample content, mostly in the live segments.
  task automatic random_run(input int n);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send_sample(CODE_W'($urandom_range(0, 15)));
      else send_sample(CODE_W'($urandom_range(16, 4095)));
      pace();
    end
  endtask

  // A plausible NTC curve with random spread on every term.
  task automatic load_plausible();
    load_coefs(32'sd230486000 + $signed($urandom_range(0, 40000000)) - 32'sd20000000,
               32'sd17397336 + $signed($urandom_range(0, 8000000)) - 32'sd4000000,
               $signed($urandom_range(0, 400000)) - 32'sd200000,
               $signed($urandom_range(0, 20000)) - 32'sd10000);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_CONST;
    cfg_wdata        = '0;
    in_chan.valid    = 1'b0;
    in_chan.adc_code = '0;
    long_hold        = 1'b0;
    burst_left       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: every live code hits a zero divisor.
    edge_codes();

    load_coefs(32'sd230486000, 32'sd17397336, 32'sd0, 32'sd6872);
    edge_codes();
    // Tiny divisor saturates high; a negative one gives negative kelvin.
    load_coefs(32'sd1, 32'sd0, 32'sd0, 32'sd0);
    send_sample(12'd2048);
    load_coefs(32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0);
    send_sample(12'd1000);
    load_coefs(-32'sd230486000, 32'sd0, 32'sd0, 32'sd0);
    send_sample(12'd3000);
    load_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    edge_codes();
    load_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    edge_codes();

    // Back up the pipe with a long receiver hold while samples keep coming.
    load_plausible();
    long_hold = 1'b1;
    random_run(200);
    // Let the sender sit idle until the pipe is empty.
    in_chan.valid <= 1'b0;
    wait (pending == 0);
    random_run(100);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2)
        load_coefs($urandom, $urandom, $urandom, $urandom);
      else
        load_plausible();
      random_run(155);
    end

    in_chan.valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("checked %0d temperatures: ok %0d, rail %0d, zero divisor %0d, saturated %0d",
             checked, status_seen[ST_OK], status_seen[ST_RAIL], status_seen[ST_ZERO],
             status_seen[ST_SAT]);
    $display("coefficient sets included reset, both extremes, tiny and negative divisors");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
